// ----- hw/rtl/dqp_pkg.sv -----
package dqp_pkg;

  // One character of the address string
  typedef struct packed {
    logic [7:0] char_byte;
    logic       start_of_string;
  } in_item_t;

  // One parse result
  typedef struct packed {
    logic [31:0] ip_address;
    logic        parse_ok;
  } out_item_t;

  localparam logic [7:0] CHAR_ZERO = 8'h30;  // '0'
  localparam logic [7:0] CHAR_NINE = 8'h39;  // '9'
  localparam logic [7:0] CHAR_DOT  = 8'h2E;  // '.'

  localparam logic [8:0] OCTET_MAX = 9'd255;
  localparam logic [8:0] OCTET_SAT = 9'd256;
  localparam logic [1:0] LAST_FIELD = 2'd3;

endpackage

// ----- hw/rtl/dotted_quad_ipv4_parser.sv -----
// Dotted-quad IPv4 address parser. Takes one ASCII character per transfer;
// start_of_string marks the first character of a new string and clears the
// parse. Four decimal fields separated by dots are read, an empty field
// counting as zero. One result is given at the first non-digit ending a
// field when: the field exceeds 255 (address 0, parse_ok 0); field one to
// three is not ended by a dot (address 0, parse_ok 0); or the fourth field
// ends (packed address, first octet in bits 31:24, parse_ok 1). Further
// characters are ignored until the next start_of_string. After reset the
// block is ready to parse, as if a string had just begun.
// Rate: one character per clock cycle, sustained while the result queue
// is not full. A taken character sits in the input register while the
// parse step works on it, and any result is written into the two-entry
// result queue when the character leaves that register. in_stall rises
// only when the result queue is full and a character is waiting in the
// input register.
module dotted_quad_ipv4_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  dqp_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output dqp_pkg::out_item_t out_item
);

  logic               item_valid;
  dqp_pkg::in_item_t  item;
  logic               advance;
  logic               res_valid;
  dqp_pkg::out_item_t res;
  logic               q_full;

  // The held character is parsed once there is room for a possible result
  assign advance = item_valid && !q_full;

  dqp_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  // Parse state and the per-character step
  dqp_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register plus skid entry
  dqp_out_queue u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (advance && res_valid),
    .push_item (res),
    .full      (q_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// ----- hw/rtl/dqp_in_stage.sv -----
module dqp_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  dqp_pkg::in_item_t in_item,
  input  logic              advance,
  output logic              item_valid,
  output dqp_pkg::in_item_t item
);

  logic              valid_r;
  logic              valid_nxt;
  dqp_pkg::in_item_t item_r;
  logic              load;

  // blocked only while a held character cannot move on
  assign in_stall  = valid_r && !advance;
  assign load      = in_valid && !in_stall;
  assign valid_nxt = load ? 1'b1 : (advance ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ----- hw/rtl/dqp_step.sv -----
module dqp_step (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               advance,
  input  dqp_pkg::in_item_t  item,
  output logic               res_valid,
  output dqp_pkg::out_item_t res
);

  logic [1:0]  field_index_r, field_index_nxt;
  logic [8:0]  octet_value_r, octet_value_nxt;
  logic [23:0] address_so_far_r, address_so_far_nxt;
  logic        finished_r, finished_nxt;

  // state as seen by this character (start clears first)
  logic [1:0]  fi;
  logic [8:0]  ov;
  logic [23:0] addr;
  logic        fin;
  logic        is_digit;
  logic [11:0] acc;

  always_comb begin
    fi   = item.start_of_string ? 2'd0  : field_index_r;
    ov   = item.start_of_string ? 9'd0  : octet_value_r;
    addr = item.start_of_string ? 24'd0 : address_so_far_r;
    fin  = item.start_of_string ? 1'b0  : finished_r;

    is_digit = (item.char_byte >= dqp_pkg::CHAR_ZERO) &&
               (item.char_byte <= dqp_pkg::CHAR_NINE);
    acc = ({3'd0, ov} << 3) + ({3'd0, ov} << 1) +
          {8'd0, item.char_byte[3:0]};

    field_index_nxt    = fi;
    octet_value_nxt    = ov;
    address_so_far_nxt = addr;
    finished_nxt       = fin;
    res_valid          = 1'b0;
    res.ip_address     = 32'd0;
    res.parse_ok       = 1'b0;

    if (!fin) begin
      if (is_digit) begin
        octet_value_nxt = (acc > {3'd0, dqp_pkg::OCTET_MAX}) ? dqp_pkg::OCTET_SAT
                                                             : acc[8:0];
      end else if (ov > dqp_pkg::OCTET_MAX) begin
        res_valid    = 1'b1;
        finished_nxt = 1'b1;
      end else if (fi != dqp_pkg::LAST_FIELD) begin
        if (item.char_byte == dqp_pkg::CHAR_DOT) begin
          address_so_far_nxt = {addr[15:0], ov[7:0]};
          field_index_nxt    = fi + 2'd1;
          octet_value_nxt    = 9'd0;
        end else begin
          res_valid    = 1'b1;
          finished_nxt = 1'b1;
        end
      end else begin
        res_valid      = 1'b1;
        res.ip_address = {addr, ov[7:0]};
        res.parse_ok   = 1'b1;
        finished_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_index_r    <= 2'd0;
      octet_value_r    <= 9'd0;
      address_so_far_r <= 24'd0;
      finished_r       <= 1'b0;
    end else if (advance) begin
      field_index_r    <= field_index_nxt;
      octet_value_r    <= octet_value_nxt;
      address_so_far_r <= address_so_far_nxt;
      finished_r       <= finished_nxt;
    end
  end

endmodule

// ----- hw/rtl/dqp_out_queue.sv -----
module dqp_out_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  dqp_pkg::out_item_t push_item,
  output logic               full,
  output logic               out_valid,
  input  logic               out_stall,
  output dqp_pkg::out_item_t out_item
);

  dqp_pkg::out_item_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       pop;

  assign full      = (count_r == 2'd2);
  assign out_valid = (count_r != 2'd0);
  assign out_item  = mem_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ----- tb/sv/dqp_result_checker.sv -----
module dqp_result_checker
  import dqp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_item,
  output int        fail_count,
  output int        outstanding,
  output int        results_checked
);

  // Shadow of the parser state
  logic [1:0]  fields_done;
  logic [8:0]  octet_acc;
  logic [23:0] addr_acc;
  logic        string_done;

  out_item_t expected_results[$];
  out_item_t want;

  // Advance the shadow parse by one character; queue a result if one is due.
  task automatic parse_char(input in_item_t ch_item);
    int        acc;
    logic      give;
    out_item_t res;
    give = 1'b0;
    res  = '0;
    if (ch_item.start_of_string) begin
      fields_done = '0;
      octet_acc   = '0;
      addr_acc    = '0;
      string_done = 1'b0;
    end
    if (!string_done) begin
      if (ch_item.char_byte >= CHAR_ZERO && ch_item.char_byte <= CHAR_NINE) begin
        acc = int'(octet_acc) * 10 + int'(ch_item.char_byte) - int'(CHAR_ZERO);
        octet_acc = (acc > int'(OCTET_MAX)) ? OCTET_SAT : 9'(acc);
      end else if (octet_acc > OCTET_MAX) begin
        give = 1'b1;                       // oversized field
      end else if (fields_done != LAST_FIELD) begin
        if (ch_item.char_byte == CHAR_DOT) begin
          addr_acc    = {addr_acc[15:0], octet_acc[7:0]};
          fields_done = fields_done + 2'd1;
          octet_acc   = '0;
        end else begin
          give = 1'b1;                     // missing dot
        end
      end else begin
        res.ip_address = {addr_acc, octet_acc[7:0]};
        res.parse_ok   = 1'b1;
        give           = 1'b1;
      end
      if (give) begin
        string_done = 1'b1;
        expected_results.push_back(res);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      fields_done     = '0;
      octet_acc       = '0;
      addr_acc        = '0;
      string_done     = 1'b0;
      expected_results.delete();
      fail_count      = 0;
      results_checked = 0;
    end else begin
      // Output first: a result can never stem from the same-edge input.
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result addr=%h ok=%b", $time,
                   out_item.ip_address, out_item.parse_ok);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (out_item.ip_address !== want.ip_address) begin
            $display("%0t: ip_address mismatch, expected %h got %h", $time,
                     want.ip_address, out_item.ip_address);
            fail_count++;
          end
          if (out_item.parse_ok !== want.parse_ok) begin
            $display("%0t: parse_ok mismatch, expected %b got %b", $time,
                     want.parse_ok, out_item.parse_ok);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall)
        parse_char(in_item);
    end
    outstanding = expected_results.size();
  end

endmodule

// ----- tb/sv/tb_dotted_quad_ipv4_parser.sv -----
module tb_dotted_quad_ipv4_parser;
  import dqp_pkg::*;

  // Characters used by the stimulus that the package does not name
  localparam logic [7:0] CHAR_NUL  = 8'h00;
  localparam logic [7:0] CHAR_HIGH = 8'hFF;

  localparam int HOLD_CYCLES  = 300;  // long receiver hold-off
  localparam int HOLD_ITEMS   = 40;   // transfers offered during the hold
  localparam int TARGET_ITEMS = 1000;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_item   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_item;

  int fail_count;
  int outstanding;
  int results_checked;

  // Stimulus-side control, written only by the stimulus process
  logic quiet    = 1'b0;   // no random idling on either side
  logic hold_req = 1'b0;   // ask the receiver for its long hold-off
  int   items_sent = 0;

  // Receiver-side state, owned by the receiver process
  int   hold_left  = 0;
  logic hold_taken = 1'b0;

  logic [7:0] char_q[$];   // characters of the string being built

  dotted_quad_ipv4_parser dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  dqp_result_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_item        (in_item),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_item       (out_item),
    .fail_count     (fail_count),
    .outstanding    (outstanding),
    .results_checked(results_checked)
  );

  always #5 clk = ~clk;

  // Hard stop in case the handshake locks up
  initial begin
    #2000000;
    $display("Timed out with %0d results outstanding", outstanding);
    $display("TEST FAILED");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off once asked for.
  // Driven at the falling edge so the block sees a settled out_stall.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < 6);
      end
    end
  end

  // Offer one character and hold it until the transfer happens.
  // Entered and left at a falling edge; valid stays high between
  // back-to-back transfers so it is never lowered and raised in one step.
  // With a 3% chance, and only when not quiet, valid drops for a random gap first.
  task automatic send_char(input logic [7:0] ch, input logic sos);
    int gap;
    if (!quiet && $urandom_range(99) < 3) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item  <= {ch, sos};
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Send char_q as one string; the first character carries the start flag
  task automatic send_string(input logic sos);
    foreach (char_q[i])
      send_char(char_q[i], (i == 0) ? sos : 1'b0);
    items_sent += char_q.size();
  endtask

  task automatic load_text(input string s);
    char_q.delete();
    for (int i = 0; i < s.len(); i++)
      char_q.push_back(s[i]);
  endtask

  // Any non-digit; NUL and dot turn up more often than chance would give
  function automatic logic [7:0] pick_non_digit();
    logic [7:0] c;
    if ($urandom_range(9) < 2)
      return ($urandom_range(1) != 0) ? CHAR_NUL : CHAR_DOT;
    do c = 8'($urandom_range(0, 255));
    while (c >= CHAR_ZERO && c <= CHAR_NINE);
    return c;
  endfunction

  // Non-digit other than dot: ends field one with a missing-dot error
  function automatic logic [7:0] pick_bad_sep();
    logic [7:0] c;
    do c = pick_non_digit();
    while (c == CHAR_DOT);
    return c;
  endfunction

  task automatic push_digits(input int v);
    string s;
    s = $sformatf("%0d", v);
    for (int i = 0; i < s.len(); i++)
      char_q.push_back(s[i]);
  endtask

  // Mostly well-formed dotted quad with random content; some fields empty,
  // oversized or padded with leading zeros, some separators wrong.
  task automatic build_address();
    int kind;
    int zeros;
    char_q.delete();
    for (int f = 0; f < 4; f++) begin
      kind = $urandom_range(99);
      if (kind < 6) begin
        // empty field, counts as zero
      end else if (kind < 16) begin
        push_digits($urandom_range(256, 99999));   // saturates
      end else begin
        zeros = ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0;
        repeat (zeros) char_q.push_back(CHAR_ZERO);
        if (kind < 23)      push_digits(255);
        else if (kind < 30) push_digits(0);
        else                push_digits($urandom_range(0, 255));
      end
      if (f < 3)
        char_q.push_back(($urandom_range(99) < 92) ? CHAR_DOT : pick_non_digit());
      else
        char_q.push_back(pick_non_digit());
    end
  endtask

  initial begin
    int iter;
    int n;
    iter = 0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // --- Directed part ---
    // No start flag after reset; three empty fields, NUL ends the fourth
    load_text("...");
    char_q.push_back(CHAR_NUL);
    send_string(1'b0);
    // Oversized first field
    load_text("256.");
    send_string(1'b1);
    // Missing dot: space ends field one
    load_text("1 ");
    send_string(1'b1);
    // Missing dot: NUL ends field two
    load_text("9.");
    char_q.push_back(CHAR_NUL);
    send_string(1'b1);
    // Top octet value in the last field, letter as terminator
    load_text("...255x");
    send_string(1'b1);
    // Ignored after a result, then an all-ones byte opening a string
    send_char(CHAR_HIGH, 1'b0);
    send_char(CHAR_HIGH, 1'b1);

    // Drain before the random part
    in_valid <= 1'b0;
    wait (outstanding == 0);
    @(negedge clk);

    // --- Random part ---
    while (items_sent < TARGET_ITEMS) begin
      iter++;

      if (iter == 20) begin
        // Receiver holds off while error-only strings keep coming, so the
        // result queue fills and the input side stalls.
        hold_req <= 1'b1;
        quiet    <= 1'b1;
        for (int k = 0; k < HOLD_ITEMS; k++)
          send_char(pick_bad_sep(), 1'b1);
        items_sent += HOLD_ITEMS;
        quiet <= 1'b0;
      end

      if (iter == 40) begin
        // Sender pause until every result is back
        in_valid <= 1'b0;
        wait (outstanding == 0);
        @(negedge clk);
      end

      // Stretch with no idling on either side
      if (iter == 50) quiet <= 1'b1;
      if (iter == 75) quiet <= 1'b0;

      if ($urandom_range(99) < 10) begin
        // Noise: random bytes with a random start flag
        n = $urandom_range(1, 6);
        repeat (n) send_char(8'($urandom_range(0, 255)), $urandom_range(99) < 30);
        items_sent += n;
      end else begin
        build_address();
        // Sometimes cut the string short; the next start flag restarts it
        if ($urandom_range(99) < 8)
          char_q = char_q[0:$urandom_range(0, char_q.size() - 2)];
        send_string(1'b1);
        // Trailing bytes after the string, ignored by the block if the string gave a result
        n = $urandom_range(0, 3);
        repeat (n) send_char(8'($urandom_range(0, 255)), 1'b0);
        items_sent += n;
      end
    end

    in_valid <= 1'b0;
    wait (outstanding == 0);
    // Let any stray result show up
    repeat (10) @(posedge clk);

    $display("Sent %0d characters over %0d random rounds; %0d results checked,",
             items_sent, iter, results_checked);
    $display("including a long output hold-off and a full drain pause.");
    if (fail_count == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- dotted_quad_ipv4_parser.f -----
hw/rtl/dqp_pkg.sv
hw/rtl/dqp_in_stage.sv
hw/rtl/dqp_step.sv
hw/rtl/dqp_out_queue.sv
hw/rtl/dotted_quad_ipv4_parser.sv
tb/sv/dqp_result_checker.sv
tb/sv/tb_dotted_quad_ipv4_parser.sv
